@@ hw/rtl/i2c_address_probe_master_defines.svh @@
// assertion macros shared by the checker of the i2c address probe master
// no dependencies
`ifndef I2C_ADDRESS_PROBE_MASTER_DEFINES_SVH
`define I2C_ADDRESS_PROBE_MASTER_DEFINES_SVH

// same-cycle implication
`define I2CAPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2capm check failed");

// next-cycle implication
`define I2CAPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2capm check failed");

`endif

@@ hw/rtl/i2capm_pkg.sv @@
// types and constants of the i2c address probe master
// no dependencies
package i2capm_pkg;

   localparam int unsigned LIMIT_W = 10;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd100;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BUSY    = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [6:0] probe_addr;
      logic       scl_in;
      logic       sda_in;
   } i2capm_req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       probe_active;
      logic       probe_done;
      logic       device_found;
      logic [1:0] status;
   } i2capm_rsp_type;

endpackage

@@ hw/rtl/i2capm_in_reg.sv @@
// input register stage of the i2c address probe master
// depends on i2capm_pkg
module i2capm_in_reg
   import i2capm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  i2capm_req_type req_data,
   output logic           item_valid,
   input  logic           item_ready,
   output i2capm_req_type item_data
);

   logic           valid_ff;
   i2capm_req_type data_ff;

   assign req_ready  = !valid_ff || item_ready;
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

endmodule

@@ hw/rtl/i2capm_seq.sv @@
// probe sequencer, stretch limit register and result register
// depends on i2capm_pkg
module i2capm_seq
   import i2capm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  i2capm_req_type     item_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output i2capm_rsp_type     rsp_data,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_CHK_WAIT, PH_START_LOW, PH_BIT_LOW, PH_BIT_RISE, PH_BIT_WAIT,
      PH_ACK_REL, PH_ACK_RISE, PH_ACK_WAIT, PH_DATA_RISE, PH_DATA_WAIT,
      PH_STOP_LOW, PH_STOP_RISE, PH_STOP_WAIT
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [3:0]         bit_ff, bit_in;
   logic [LIMIT_W-1:0] wait_ff, wait_in;
   logic [7:0]         shift_ff, shift_in;
   logic               ack_ff, ack_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               rsp_valid_ff;
   i2capm_rsp_type     rsp_ff, rsp_in;

   logic               step;
   logic [LIMIT_W-1:0] wait_inc;
   logic               wait_out;
   logic               addr_bit;
   logic               done;
   logic [1:0]         status;
   logic               found;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign step       = item_valid && item_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign wait_inc = wait_ff + 1'b1;
   assign wait_out = (wait_inc >= limit_ff) || (wait_inc == '0);
   assign addr_bit = shift_ff[bit_ff[2:0]];

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      wait_in  = wait_ff;
      shift_in = shift_ff;
      ack_in   = ack_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      done     = 1'b0;
      status   = STATUS_OK;
      found    = 1'b0;

      if (item_data.req_type == REQ_START) begin
         if (phase_ff == PH_IDLE) begin
            shift_in = {item_data.probe_addr, 1'b1};
            bit_in   = 4'd7;
            wait_in  = '0;
            ack_in   = 1'b0;
            scl_in   = 1'b1;
            sda_in   = 1'b1;
            phase_in = PH_CHK_WAIT;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               scl_in = 1'b1;
               sda_in = 1'b1;
            end
            PH_CHK_WAIT: begin
               if (item_data.scl_in) begin
                  wait_in = '0;
                  if (item_data.sda_in) begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b0;
                     phase_in = PH_START_LOW;
                  end else begin
                     done   = 1'b1;
                     status = STATUS_BUSY;
                  end
               end else begin
                  wait_in = wait_inc;
                  if (wait_out) begin
                     done   = 1'b1;
                     status = STATUS_BUSY;
                  end
               end
            end
            PH_START_LOW: begin
               scl_in   = 1'b0;
               sda_in   = 1'b0;
               phase_in = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
               scl_in   = 1'b0;
               sda_in   = addr_bit;
               phase_in = PH_BIT_RISE;
            end
            PH_BIT_RISE: begin
               scl_in   = 1'b1;
               sda_in   = addr_bit;
               wait_in  = '0;
               phase_in = PH_BIT_WAIT;
            end
            PH_BIT_WAIT: begin
               if (item_data.scl_in) begin
                  wait_in = '0;
                  scl_in  = 1'b0;
                  sda_in  = addr_bit;
                  if (bit_ff == 4'd0) begin
                     phase_in = PH_ACK_REL;
                  end else begin
                     bit_in   = bit_ff - 1'b1;
                     phase_in = PH_BIT_LOW;
                  end
               end else begin
                  wait_in = wait_inc;
                  if (wait_out) begin
                     done   = 1'b1;
                     status = STATUS_TIMEOUT;
                  end
               end
            end
            PH_ACK_REL: begin
               scl_in   = 1'b0;
               sda_in   = 1'b1;
               phase_in = PH_ACK_RISE;
            end
            PH_ACK_RISE: begin
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               wait_in  = '0;
               phase_in = PH_ACK_WAIT;
            end
            PH_ACK_WAIT: begin
               if (item_data.scl_in) begin
                  wait_in = '0;
                  ack_in  = !item_data.sda_in;
                  scl_in  = 1'b0;
                  sda_in  = 1'b1;
                  if (!item_data.sda_in) begin
                     bit_in   = 4'd8;
                     shift_in = '0;
                     phase_in = PH_DATA_RISE;
                  end else begin
                     phase_in = PH_STOP_LOW;
                  end
               end else begin
                  wait_in = wait_inc;
                  if (wait_out) begin
                     done   = 1'b1;
                     status = STATUS_TIMEOUT;
                  end
               end
            end
            PH_DATA_RISE: begin
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               wait_in  = '0;
               phase_in = PH_DATA_WAIT;
            end
            PH_DATA_WAIT: begin
               if (item_data.scl_in) begin
                  wait_in = '0;
                  scl_in  = 1'b0;
                  sda_in  = 1'b1;
                  if (bit_ff == 4'd0) begin
                     phase_in = PH_STOP_LOW;
                  end else begin
                     shift_in = {shift_ff[6:0], item_data.sda_in};
                     bit_in   = bit_ff - 1'b1;
                     phase_in = PH_DATA_RISE;
                  end
               end else begin
                  wait_in = wait_inc;
                  if (wait_out) begin
                     done   = 1'b1;
                     status = STATUS_TIMEOUT;
                  end
               end
            end
            PH_STOP_LOW: begin
               scl_in   = 1'b0;
               sda_in   = 1'b0;
               phase_in = PH_STOP_RISE;
            end
            PH_STOP_RISE: begin
               scl_in   = 1'b1;
               sda_in   = 1'b0;
               wait_in  = '0;
               phase_in = PH_STOP_WAIT;
            end
            PH_STOP_WAIT: begin
               if (item_data.scl_in) begin
                  wait_in = '0;
                  done    = 1'b1;
                  found   = ack_ff;
               end else begin
                  wait_in = wait_inc;
                  if (wait_out) begin
                     done   = 1'b1;
                     status = STATUS_TIMEOUT;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
            end
         endcase
      end

      // any finish returns to idle with both lines released
      if (done) begin
         phase_in = PH_IDLE;
         wait_in  = '0;
         scl_in   = 1'b1;
         sda_in   = 1'b1;
      end

      rsp_in.scl_out      = scl_in;
      rsp_in.sda_out      = sda_in;
      rsp_in.probe_active = (phase_in != PH_IDLE);
      rsp_in.probe_done   = done;
      rsp_in.device_found = found;
      rsp_in.status       = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_ff       <= '0;
         wait_ff      <= '0;
         shift_ff     <= '0;
         ack_ff       <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (item_ready) begin
            rsp_valid_ff <= item_valid;
         end
         if (step) begin
            phase_ff <= phase_in;
            bit_ff   <= bit_in;
            wait_ff  <= wait_in;
            shift_ff <= shift_in;
            ack_ff   <= ack_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
         end
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ hw/rtl/i2c_address_probe_master.sv @@
// i2c address probe master: one word per cycle unless rsp_ready stalls, each word is one bit-time step
// from req acceptance to rsp valid a word passes the input register, then the result register
// rsp_ready low stalls both registers; a new word is taken while a result waits
// synchronous active-high reset: idle, lines released, stretch limit 100
// depends on i2capm_pkg, i2capm_in_reg, i2capm_seq
module i2c_address_probe_master
   import i2capm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  i2capm_req_type     req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output i2capm_rsp_type     rsp_data,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   logic           item_valid;
   logic           item_ready;
   i2capm_req_type item_data;

   i2capm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item_data  (item_data)
   );

   i2capm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item_data   (item_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

@@ hw/rtl/i2capm_checker.sv @@
// port-level assertions for the i2c address probe master, bound to the top level
// depends on i2capm_pkg and i2c_address_probe_master_defines.svh
`include "i2c_address_probe_master_defines.svh"

module i2capm_checker
   import i2capm_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           rsp_valid,
   input logic           rsp_ready,
   input i2capm_rsp_type rsp_data
);

   logic rsp_error;

   assign rsp_error = rsp_valid && rsp_data.probe_done && (rsp_data.status != STATUS_OK);

   `I2CAPM_ASSERT_NOW(done_ends_probe, clock, reset,
      rsp_valid && rsp_data.probe_done, !rsp_data.probe_active)

   `I2CAPM_ASSERT_NOW(found_only_ok_done, clock, reset,
      rsp_valid && rsp_data.device_found,
      rsp_data.probe_done && (rsp_data.status == STATUS_OK))

   `I2CAPM_ASSERT_NOW(status_only_on_done, clock, reset,
      rsp_valid && (rsp_data.status != STATUS_OK), rsp_data.probe_done)

   `I2CAPM_ASSERT_NOW(error_releases_lines, clock, reset,
      rsp_error, rsp_data.scl_out && rsp_data.sda_out)

   `I2CAPM_ASSERT_NEXT(rsp_holds_while_stalled, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind i2c_address_probe_master i2capm_checker u_checker (.*);

@@ dv/tb_top.sv @@
// testbench for the i2c address probe master: a directed table, then a bus model
// that answers the probe, with every word checked against the table or a predictor of the sequencer
// depends on i2capm_pkg and i2c_address_probe_master
`timescale 1ns / 100ps

module tb_top;
   import i2capm_pkg::*;

   localparam int unsigned RUN_LIMIT = 1000000;
   localparam int unsigned ROUND_WORDS = 179;

   localparam i2capm_rsp_type EXP_IDLE =
      i2capm_rsp_type'({1'b1, 1'b1, 1'b0, 1'b0, 1'b0, STATUS_OK});
   localparam i2capm_rsp_type EXP_ARMED =
      i2capm_rsp_type'({1'b1, 1'b1, 1'b1, 1'b0, 1'b0, STATUS_OK});
   localparam i2capm_rsp_type EXP_BUSY =
      i2capm_rsp_type'({1'b1, 1'b1, 1'b0, 1'b1, 1'b0, STATUS_BUSY});
   localparam i2capm_rsp_type EXP_TIMEOUT =
      i2capm_rsp_type'({1'b1, 1'b1, 1'b0, 1'b1, 1'b0, STATUS_TIMEOUT});

   typedef enum logic [4:0] {
      PH_IDLE, PH_CHK_WAIT, PH_START_LOW, PH_BIT_LOW, PH_BIT_RISE, PH_BIT_WAIT,
      PH_ACK_REL, PH_ACK_RISE, PH_ACK_WAIT, PH_DATA_RISE, PH_DATA_WAIT,
      PH_STOP_LOW, PH_STOP_RISE, PH_STOP_WAIT
   } probe_phase_type;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;
   typedef enum logic {ROW_WORD, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      i2capm_req_type     word;
      logic [LIMIT_W-1:0] cfg_value;
      logic               typed;
      i2capm_rsp_type     rsp;
   } probe_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   i2capm_req_type     req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b1;
   i2capm_rsp_type     rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;

   // predictor state
   probe_phase_type    probe_phase = PH_IDLE;
   logic [3:0]         bit_idx = '0;
   logic [LIMIT_W-1:0] stretch_count = '0;
   logic [7:0]         shift_reg = '0;
   logic               acked = 1'b0;
   logic               drv_scl = 1'b1;
   logic               drv_sda = 1'b1;
   logic [LIMIT_W-1:0] limit_q = LIMIT_RESET;

   // bus model state
   int                 stretch_left = 0;
   logic               slave_acks = 1'b0;
   logic               bus_held = 1'b0;

   i2capm_rsp_type     probe_exp_q[$];
   probe_row_type      dir_rows[$];
   i2capm_rsp_type     rsp_want;
   idle_mode_type      idle_mode = IDLE_NONE;
   int unsigned        fail_count = 0;
   int unsigned        cycle_count = 0;
   int unsigned        round_limits [8] = '{3, 1023, 1, 100, 2, 0, 17, 1023};

   i2c_address_probe_master dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic int scl_wait(input logic scl);
      if (scl) begin
         stretch_count = '0;
         return 1;
      end
      stretch_count = stretch_count + 1'b1;
      if (stretch_count >= limit_q || stretch_count == '0) return -1;
      return 0;
   endfunction

   function automatic i2capm_rsp_type predict_probe_step(input i2capm_req_type w);
      i2capm_rsp_type r;
      int wr;
      logic done;
      logic found;
      logic [1:0] st;
      done = 1'b0;
      found = 1'b0;
      st = STATUS_OK;
      if (w.req_type == REQ_START) begin
         if (probe_phase == PH_IDLE) begin
            shift_reg = {w.probe_addr, 1'b1};
            bit_idx = 4'd7;
            stretch_count = '0;
            acked = 1'b0;
            drv_scl = 1'b1;
            drv_sda = 1'b1;
            probe_phase = PH_CHK_WAIT;
         end
      end else begin
         case (probe_phase)
            PH_IDLE: begin
               drv_scl = 1'b1;
               drv_sda = 1'b1;
            end
            PH_CHK_WAIT: begin
               wr = scl_wait(w.scl_in);
               if (wr > 0 && w.sda_in) begin
                  drv_scl = 1'b1;
                  drv_sda = 1'b0;
                  probe_phase = PH_START_LOW;
               end else if (wr != 0) begin
                  done = 1'b1;
                  st = STATUS_BUSY;
               end
            end
            PH_START_LOW: begin
               drv_scl = 1'b0;
               drv_sda = 1'b0;
               probe_phase = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
               drv_scl = 1'b0;
               drv_sda = shift_reg[bit_idx[2:0]];
               probe_phase = PH_BIT_RISE;
            end
            PH_BIT_RISE: begin
               drv_scl = 1'b1;
               drv_sda = shift_reg[bit_idx[2:0]];
               stretch_count = '0;
               probe_phase = PH_BIT_WAIT;
            end
            PH_BIT_WAIT: begin
               wr = scl_wait(w.scl_in);
               if (wr > 0) begin
                  drv_scl = 1'b0;
                  drv_sda = shift_reg[bit_idx[2:0]];
                  if (bit_idx == 4'd0) begin
                     probe_phase = PH_ACK_REL;
                  end else begin
                     bit_idx = bit_idx - 4'd1;
                     probe_phase = PH_BIT_LOW;
                  end
               end else if (wr < 0) begin
                  done = 1'b1;
                  st = STATUS_TIMEOUT;
               end
            end
            PH_ACK_REL: begin
               drv_scl = 1'b0;
               drv_sda = 1'b1;
               probe_phase = PH_ACK_RISE;
            end
            PH_ACK_RISE: begin
               drv_scl = 1'b1;
               drv_sda = 1'b1;
               stretch_count = '0;
               probe_phase = PH_ACK_WAIT;
            end
            PH_ACK_WAIT: begin
               wr = scl_wait(w.scl_in);
               if (wr > 0) begin
                  acked = ~w.sda_in;
                  drv_scl = 1'b0;
                  drv_sda = 1'b1;
                  if (acked) begin
                     bit_idx = 4'd8;
                     shift_reg = '0;
                     probe_phase = PH_DATA_RISE;
                  end else begin
                     probe_phase = PH_STOP_LOW;
                  end
               end else if (wr < 0) begin
                  done = 1'b1;
                  st = STATUS_TIMEOUT;
               end
            end
            PH_DATA_RISE: begin
               drv_scl = 1'b1;
               drv_sda = 1'b1;
               stretch_count = '0;
               probe_phase = PH_DATA_WAIT;
            end
            PH_DATA_WAIT: begin
               wr = scl_wait(w.scl_in);
               if (wr > 0) begin
                  drv_scl = 1'b0;
                  drv_sda = 1'b1;
                  if (bit_idx == 4'd0) begin
                     probe_phase = PH_STOP_LOW;
                  end else begin
                     shift_reg = {shift_reg[6:0], w.sda_in};
                     bit_idx = bit_idx - 4'd1;
                     probe_phase = PH_DATA_RISE;
                  end
               end else if (wr < 0) begin
                  done = 1'b1;
                  st = STATUS_TIMEOUT;
               end
            end
            PH_STOP_LOW: begin
               drv_scl = 1'b0;
               drv_sda = 1'b0;
               probe_phase = PH_STOP_RISE;
            end
            PH_STOP_RISE: begin
               drv_scl = 1'b1;
               drv_sda = 1'b0;
               stretch_count = '0;
               probe_phase = PH_STOP_WAIT;
            end
            PH_STOP_WAIT: begin
               wr = scl_wait(w.scl_in);
               if (wr > 0) begin
                  done = 1'b1;
                  st = STATUS_OK;
                  found = acked;
               end else if (wr < 0) begin
                  done = 1'b1;
                  st = STATUS_TIMEOUT;
               end
            end
            default: begin
               probe_phase = PH_IDLE;
               drv_scl = 1'b1;
               drv_sda = 1'b1;
            end
         endcase
      end
      if (done) begin
         probe_phase = PH_IDLE;
         stretch_count = '0;
         drv_scl = 1'b1;
         drv_sda = 1'b1;
      end
      r.scl_out = drv_scl;
      r.sda_out = drv_sda;
      r.probe_active = (probe_phase != PH_IDLE);
      r.probe_done = done;
      r.device_found = found;
      r.status = st;
      return r;
   endfunction

   function automatic probe_row_type word_row(input logic rt, input logic [6:0] addr,
                                              input logic scl, input logic sda,
                                              input logic typed, input i2capm_rsp_type rsp);
      probe_row_type row;
      row.kind = ROW_WORD;
      row.word.req_type = rt;
      row.word.probe_addr = addr;
      row.word.scl_in = scl;
      row.word.sda_in = sda;
      row.cfg_value = '0;
      row.typed = typed;
      row.rsp = rsp;
      return row;
   endfunction

   function automatic probe_row_type cfg_row(input logic [LIMIT_W-1:0] v);
      probe_row_type row;
      row = word_row(REQ_TICK, 7'h00, 1'b0, 1'b0, 1'b0, EXP_IDLE);
      row.kind = ROW_CFG;
      row.cfg_value = v;
      return row;
   endfunction

   // slave side of the bus: follows the master's drive, with stretching,
   // a held bus, ack or nack, random data and some noise words
   task automatic next_bus_word(output i2capm_req_type w);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      w.req_type = 1'($urandom_range(0, 1));
      w.probe_addr = 7'($urandom_range(0, 127));
      w.scl_in = 1'($urandom_range(0, 1));
      w.sda_in = 1'($urandom_range(0, 1));
      if (pick < 6) return;
      if (probe_phase == PH_IDLE) begin
         w.req_type = (pick < 75) ? REQ_START : REQ_TICK;
         if (w.req_type == REQ_START) begin
            slave_acks = ($urandom_range(0, 2) != 0);
            bus_held = ($urandom_range(0, 11) == 0);
            stretch_left = 0;
         end
         return;
      end
      w.req_type = REQ_TICK;
      if (stretch_left == 0 && drv_scl && $urandom_range(0, 7) == 0 &&
          (probe_phase == PH_CHK_WAIT || probe_phase == PH_BIT_WAIT ||
           probe_phase == PH_ACK_WAIT || probe_phase == PH_DATA_WAIT ||
           probe_phase == PH_STOP_WAIT)) begin
         if ($urandom_range(0, (limit_q > 64) ? 59 : 5) == 0)
            stretch_left = int'(limit_q) + int'($urandom_range(0, 2));
         else
            stretch_left = int'($urandom_range(1, 3));
      end
      if (stretch_left > 0) begin
         w.scl_in = 1'b0;
         stretch_left--;
      end else begin
         w.scl_in = drv_scl;
      end
      case (probe_phase)
         PH_CHK_WAIT:  w.sda_in = drv_sda & ~bus_held;
         PH_ACK_WAIT:  w.sda_in = drv_sda & ~slave_acks;
         PH_DATA_WAIT: w.sda_in = drv_sda & w.sda_in;
         default:      w.sda_in = drv_sda;
      endcase
   endtask

   task automatic send_word(input i2capm_req_type w, input logic typed,
                            input i2capm_rsp_type typed_rsp);
      i2capm_rsp_type p;
      while ((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 71) ||
             (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 9)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      p = predict_probe_step(w);
      probe_exp_q.push_back(typed ? typed_rsp : p);
      @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      req_valid <= 1'b0;
      while (probe_exp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      limit_q = v;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= !((idle_mode == IDLE_RECV && $urandom_range(0, 99) < 71) ||
                     (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 9));
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (probe_exp_q.size() == 0) begin
            $display("%0t unexpected word: expected none, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            rsp_want = probe_exp_q.pop_front();
            check_field("scl_out", rsp_want.scl_out, rsp_data.scl_out);
            check_field("sda_out", rsp_want.sda_out, rsp_data.sda_out);
            check_field("probe_active", rsp_want.probe_active, rsp_data.probe_active);
            check_field("probe_done", rsp_want.probe_done, rsp_data.probe_done);
            check_field("device_found", rsp_want.device_found, rsp_data.device_found);
            check_field("status", rsp_want.status, rsp_data.status);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("i2c_address_probe_master regression: fail");
         $finish;
      end
   end

   initial begin
      i2capm_req_type w;
      int unsigned sent;
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b0, 1'b0, 1'b1, EXP_IDLE));
      dir_rows.push_back(word_row(REQ_TICK, 7'h7F, 1'b1, 1'b1, 1'b1, EXP_IDLE));
      dir_rows.push_back(word_row(REQ_START, 7'h7F, 1'b0, 1'b0, 1'b1, EXP_ARMED));
      dir_rows.push_back(word_row(REQ_START, 7'h2A, 1'b1, 1'b1, 1'b1, EXP_ARMED));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b1, 1'b0, 1'b1, EXP_BUSY));
      dir_rows.push_back(word_row(REQ_START, 7'h00, 1'b1, 1'b1, 1'b1, EXP_ARMED));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b0, 1'b1, 1'b1, EXP_ARMED));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b1, 1'b1, 1'b0, EXP_IDLE));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b1, 1'b1, 1'b0, EXP_IDLE));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b0, 1'b0, 1'b0, EXP_IDLE));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b1, 1'b1, 1'b0, EXP_IDLE));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b0, 1'b1, 1'b0, EXP_IDLE));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b1, 1'b1, 1'b0, EXP_IDLE));
      // limit of one: first low sample in an address bit times out
      dir_rows.push_back(cfg_row(10'd1));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b1, 1'b1, 1'b0, EXP_IDLE));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b1, 1'b1, 1'b0, EXP_IDLE));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b0, 1'b1, 1'b1, EXP_TIMEOUT));
      // zero limit acts as one
      dir_rows.push_back(cfg_row(10'd0));
      dir_rows.push_back(word_row(REQ_START, 7'h3C, 1'b1, 1'b1, 1'b1, EXP_ARMED));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b0, 1'b1, 1'b1, EXP_BUSY));
      dir_rows.push_back(cfg_row(10'd1023));
      dir_rows.push_back(word_row(REQ_START, 7'h55, 1'b1, 1'b1, 1'b1, EXP_ARMED));
      dir_rows.push_back(word_row(REQ_TICK, 7'h00, 1'b1, 1'b1, 1'b0, EXP_IDLE));
      dir_rows.push_back(word_row(REQ_START, 7'h7F, 1'b0, 1'b0, 1'b0, EXP_IDLE));

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG)
            write_limit(dir_rows[i].cfg_value);
         else
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].rsp);
      end

      for (int round = 0; round < 8; round++) begin
         write_limit(LIMIT_W'(round_limits[round]));
         idle_mode = idle_mode_type'(round % 4);
         sent = 0;
         while (sent < ROUND_WORDS) begin
            next_bus_word(w);
            send_word(w, 1'b0, EXP_IDLE);
            sent++;
         end
      end

      req_valid <= 1'b0;
      idle_mode = IDLE_NONE;
      while (probe_exp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("i2c_address_probe_master regression: pass");
      else
         $display("i2c_address_probe_master regression: fail");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/i2capm_pkg.sv
hw/rtl/i2capm_in_reg.sv
hw/rtl/i2capm_seq.sv
hw/rtl/i2c_address_probe_master.sv
hw/rtl/i2capm_checker.sv
dv/tb_top.sv
